FILE: src/kmw_pkg.sv
// Shared word types and constants for the minimum spanning forest weight unit.
package kmw_pkg;

    localparam int VERTEX_BITS = 6;
    localparam int FIELD_WEIGHT_BITS = 16;
    localparam int TOTAL_BITS = 22;
    localparam int VERTEX_COUNT_BITS = 7;
    localparam int LIMIT_BITS = 11;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 22'h3FFFFF;
    localparam logic [VERTEX_COUNT_BITS-1:0] VERTEX_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic [VERTEX_BITS-1:0]       vertex_a;
        logic [VERTEX_BITS-1:0]       vertex_b;
        logic [FIELD_WEIGHT_BITS-1:0] weight;
        logic                         last_edge;
    } edge_in_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] total_weight;
        logic                  edge_overflow;
        logic                  bad_vertex;
    } mst_result_t;

endpackage

FILE: src/kmw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/kruskal_mst_weight_unit.sv
// Top level: edge collection with insertion sort, then union-find scan for the forest weight.
//
//  channel | direction | handshake                  | word
//  in      | input     | in_valid / in_stall        | edge_in_t
//  out     | output    | out_valid / out_stall      | mst_result_t
//  cfg     | input     | cfg_wr_en (no wait)        | vertex_count
//
// A stored edge is inserted into sorted order, each heavier entry it moves past shifted up one place.
// On the last edge all MAX_VERTICES parent entries are reset, then for each edge the parent
// links are followed from both endpoints to their roots, and differing roots are merged.
// Reset clears control state and sets vertex_count to 64; the edge RAM is never cleared.
// in_stall is high whenever the sequencer is busy; a result held by out_stall does not
// block new edges, only the next result.
module kruskal_mst_weight_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  kmw_pkg::edge_in_t                     in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output kmw_pkg::mst_result_t                  out_data,
    input  logic                                  cfg_wr_en,
    input  logic [kmw_pkg::VERTEX_COUNT_BITS-1:0] cfg_wr_data
);

    import kmw_pkg::*;

    localparam int WB = (WEIGHT_BITS < FIELD_WEIGHT_BITS) ? WEIGHT_BITS : FIELD_WEIGHT_BITS;
    localparam int EDGE_BITS = 2 * VERTEX_BITS + WB;
    localparam int EW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VW = $clog2(MAX_VERTICES);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_INS_RD  = 10'b0000000010,
        S_INS_CMP = 10'b0000000100,
        S_INIT    = 10'b0000001000,
        S_E_RD    = 10'b0000010000,
        S_E_WAIT  = 10'b0000100000,
        S_F_RD    = 10'b0001000000,
        S_F_CMP   = 10'b0010000000,
        S_UNION   = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    state_t                 state_reg;
    logic [VERTEX_COUNT_BITS-1:0] vcount_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          j_reg;
    logic [CW-1:0]          i_reg;
    logic [VW-1:0]          k_reg;
    logic [EDGE_BITS-1:0]   cur_reg;
    logic                   last_reg;
    logic                   ovf_reg;
    logic                   bad_reg;
    logic [TOTAL_BITS-1:0]  sum_reg;
    logic [VW-1:0]          r_reg;
    logic [VW-1:0]          ra_reg;
    logic [VW-1:0]          vb_reg;
    logic [WB-1:0]          w_reg;
    logic                   phase_b_reg;
    logic                   out_valid_reg;
    mst_result_t            out_data_reg;

    logic                   e_wr_en;
    logic [EW-1:0]          e_wr_addr;
    logic [EDGE_BITS-1:0]   e_wr_data;
    logic                   e_rd_en;
    logic [EW-1:0]          e_rd_addr;
    logic [EDGE_BITS-1:0]   e_rd_data;
    logic                   p_wr_en;
    logic [VW-1:0]          p_wr_addr;
    logic [VW-1:0]          p_wr_data;
    logic                   p_rd_en;
    logic [VW-1:0]          p_rd_data;

    logic [LIMIT_BITS-1:0]  limit;
    logic                   in_bad;
    logic                   accept;
    logic [TOTAL_BITS:0]    sum_wide;
    logic [CW-1:0]          j_dec;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign limit = (LIMIT_BITS'(vcount_reg) > LIMIT_BITS'(MAX_VERTICES))
                   ? LIMIT_BITS'(MAX_VERTICES) : LIMIT_BITS'(vcount_reg);
    assign in_bad = (LIMIT_BITS'(in_data.vertex_a) >= limit)
                 || (LIMIT_BITS'(in_data.vertex_b) >= limit);
    assign sum_wide = {1'b0, sum_reg} + (TOTAL_BITS + 1)'(w_reg);
    assign j_dec = j_reg - CW'(1);

    // The shared comparator decides between shifting the stored edge up and placing the new one.
    always_comb
    begin
        e_wr_en = 1'b0;
        e_wr_addr = j_reg[EW-1:0];
        e_wr_data = cur_reg;
        e_rd_en = 1'b0;
        e_rd_addr = i_reg[EW-1:0];
        case (state_reg)
            S_INS_RD:
            begin
                if (j_reg == '0)
                begin
                    e_wr_en = 1'b1;
                end
                else
                begin
                    e_rd_en = 1'b1;
                    e_rd_addr = j_dec[EW-1:0];
                end
            end
            S_INS_CMP:
            begin
                e_wr_en = 1'b1;
                if (e_rd_data[WB-1:0] > cur_reg[WB-1:0])
                begin
                    e_wr_data = e_rd_data;
                end
            end
            S_E_RD:
            begin
                e_rd_en = 1'b1;
            end
            default:
            begin
                e_rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        p_wr_en = 1'b0;
        p_wr_addr = k_reg;
        p_wr_data = k_reg;
        p_rd_en = (state_reg == S_F_RD);
        case (state_reg)
            S_INIT:
            begin
                p_wr_en = 1'b1;
            end
            S_UNION:
            begin
                p_wr_en = (ra_reg != r_reg);
                p_wr_addr = (ra_reg < r_reg) ? r_reg : ra_reg;
                p_wr_data = (ra_reg < r_reg) ? ra_reg : r_reg;
            end
            default:
            begin
                p_wr_en = 1'b0;
            end
        endcase
    end

    kmw_ram #(
        .WIDTH (EDGE_BITS),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (e_wr_en),
        .wr_addr (e_wr_addr),
        .wr_data (e_wr_data),
        .rd_en   (e_rd_en),
        .rd_addr (e_rd_addr),
        .rd_data (e_rd_data)
    );

    kmw_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (p_wr_en),
        .wr_addr (p_wr_addr),
        .wr_data (p_wr_data),
        .rd_en   (p_rd_en),
        .rd_addr (r_reg),
        .rd_data (p_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcount_reg <= VERTEX_COUNT_RESET;
            count_reg <= '0;
            j_reg <= '0;
            i_reg <= '0;
            k_reg <= '0;
            cur_reg <= '0;
            last_reg <= 1'b0;
            ovf_reg <= 1'b0;
            bad_reg <= 1'b0;
            sum_reg <= '0;
            r_reg <= '0;
            ra_reg <= '0;
            vb_reg <= '0;
            w_reg <= '0;
            phase_b_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
            end
            // In the done step the valid flag is handled below.
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= in_data.last_edge;
                        cur_reg <= {in_data.vertex_a, in_data.vertex_b, in_data.weight[WB-1:0]};
                        j_reg <= count_reg;
                        k_reg <= '0;
                        if (in_bad)
                        begin
                            bad_reg <= 1'b1;
                            state_reg <= in_data.last_edge ? S_INIT : S_IDLE;
                        end
                        else if (count_reg >= CW'(MAX_EDGES))
                        begin
                            ovf_reg <= 1'b1;
                            state_reg <= in_data.last_edge ? S_INIT : S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_INS_RD;
                        end
                    end
                end
                S_INS_RD:
                begin
                    if (j_reg == '0)
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= last_reg ? S_INIT : S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP:
                begin
                    if (e_rd_data[WB-1:0] > cur_reg[WB-1:0])
                    begin
                        j_reg <= j_dec;
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= last_reg ? S_INIT : S_IDLE;
                    end
                end
                S_INIT:
                begin
                    k_reg <= k_reg + VW'(1);
                    i_reg <= '0;
                    if (k_reg == VW'(MAX_VERTICES - 1))
                    begin
                        state_reg <= (count_reg == '0) ? S_DONE : S_E_RD;
                    end
                end
                S_E_RD:
                begin
                    state_reg <= S_E_WAIT;
                end
                S_E_WAIT:
                begin
                    r_reg <= VW'(e_rd_data[EDGE_BITS-1 -: VERTEX_BITS]);
                    vb_reg <= VW'(e_rd_data[WB +: VERTEX_BITS]);
                    w_reg <= e_rd_data[WB-1:0];
                    phase_b_reg <= 1'b0;
                    state_reg <= S_F_RD;
                end
                S_F_RD:
                begin
                    state_reg <= S_F_CMP;
                end
                S_F_CMP:
                begin
                    if (p_rd_data != r_reg)
                    begin
                        r_reg <= p_rd_data;
                        state_reg <= S_F_RD;
                    end
                    else if (!phase_b_reg)
                    begin
                        ra_reg <= r_reg;
                        r_reg <= vb_reg;
                        phase_b_reg <= 1'b1;
                        state_reg <= S_F_RD;
                    end
                    else
                    begin
                        state_reg <= S_UNION;
                    end
                end
                S_UNION:
                begin
                    if (ra_reg != r_reg)
                    begin
                        sum_reg <= (sum_wide > (TOTAL_BITS + 1)'(TOTAL_MAX))
                                   ? TOTAL_MAX : sum_wide[TOTAL_BITS-1:0];
                    end
                    i_reg <= i_reg + CW'(1);
                    state_reg <= ((i_reg + CW'(1)) == count_reg) ? S_DONE : S_E_RD;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= '{total_weight: sum_reg,
                                          edge_overflow: ovf_reg,
                                          bad_vertex: bad_reg};
                        count_reg <= '0;
                        sum_reg <= '0;
                        ovf_reg <= 1'b0;
                        bad_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_EDGES))
        else $error("edge count beyond capacity");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done step");

    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last_edge) |=> in_stall)
        else $error("last edge did not start the computation");

    a_union_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UNION) |-> $past(state_reg == S_F_CMP) && phase_b_reg)
        else $error("merge reached before both roots were found");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the minimum spanning forest weight unit.
`timescale 1ns / 100ps

module tb_top;
    import kmw_pkg::*;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES = 256;
    localparam int STALL_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    edge_in_t in_data;
    logic out_valid;
    logic out_stall;
    mst_result_t out_data;
    logic cfg_wr_en;
    logic [VERTEX_COUNT_BITS-1:0] cfg_wr_data;

    kruskal_mst_weight_unit #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES(MAX_EDGES),
        .WEIGHT_BITS(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    edge_in_t edge_q[$];
    mst_result_t forest_q[$];

    int snd_idle_pct;
    int rcv_idle_pct;
    logic drain_hold;
    int fail_count;
    int graph_count;
    int result_count;
    int idle_cycles;

    // Predictor state.
    logic [VERTEX_COUNT_BITS-1:0] vc_model;
    logic [5:0] st_a [MAX_EDGES];
    logic [5:0] st_b [MAX_EDGES];
    logic [15:0] st_w [MAX_EDGES];
    int stored;
    logic ovf_flag;
    logic bad_flag;

    function automatic int root_of(ref int parent [MAX_VERTICES], input int x);
        int r;
        int nx;
        r = x;
        while (parent[r] != r)
            r = parent[r];
        while (parent[x] != r)
        begin
            nx = parent[x];
            parent[x] = r;
            x = nx;
        end
        return r;
    endfunction

    function automatic logic [TOTAL_BITS-1:0] forest_weight();
        int parent [MAX_VERTICES];
        int ra;
        int rb;
        int j;
        logic [5:0] ta;
        logic [5:0] tb;
        logic [15:0] tw;
        longint sum;
        // Stable insertion sort by weight.
        for (int i = 1; i < stored; i++)
        begin
            ta = st_a[i];
            tb = st_b[i];
            tw = st_w[i];
            j = i;
            while (j > 0 && st_w[j-1] > tw)
            begin
                st_a[j] = st_a[j-1];
                st_b[j] = st_b[j-1];
                st_w[j] = st_w[j-1];
                j--;
            end
            st_a[j] = ta;
            st_b[j] = tb;
            st_w[j] = tw;
        end
        for (int i = 0; i < MAX_VERTICES; i++)
            parent[i] = i;
        sum = 0;
        for (int i = 0; i < stored; i++)
        begin
            ra = root_of(parent, st_a[i]);
            rb = root_of(parent, st_b[i]);
            if (ra != rb)
            begin
                sum += st_w[i];
                if (ra < rb)
                    parent[rb] = ra;
                else
                    parent[ra] = rb;
            end
        end
        return (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
    endfunction

    task automatic take_edge(input edge_in_t e);
        int lim;
        mst_result_t r;
        lim = (vc_model > MAX_VERTICES) ? MAX_VERTICES : vc_model;
        if (e.vertex_a >= lim || e.vertex_b >= lim)
        begin
            bad_flag = 1'b1;
        end
        else if (stored >= MAX_EDGES)
        begin
            ovf_flag = 1'b1;
        end
        else
        begin
            st_a[stored] = e.vertex_a;
            st_b[stored] = e.vertex_b;
            st_w[stored] = e.weight;
            stored++;
        end
        if (e.last_edge)
        begin
            r.total_weight = forest_weight();
            r.edge_overflow = ovf_flag;
            r.bad_vertex = bad_flag;
            forest_q.insert(forest_q.size(), r);
            stored = 0;
            ovf_flag = 1'b0;
            bad_flag = 1'b0;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: a word stays on the bus unchanged until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
            if (in_valid && in_stall)
            begin
                in_valid <= 1'b1;
            end
            else
            begin
                if (in_valid)
                    take_edge(in_data);
                if (drain_hold || edge_q.size() == 0 || $urandom_range(99) < snd_idle_pct)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= edge_q.pop_front();
                end
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (forest_q.size() == 0)
                begin
                    $error("unexpected result word %h", out_data);
                    fail_count++;
                end
                else
                begin
                    mst_result_t ex;
                    ex = forest_q.pop_front();
                    if (out_data.total_weight !== ex.total_weight)
                    begin
                        $error("total_weight expected %0d actual %0d",
                               ex.total_weight, out_data.total_weight);
                        fail_count++;
                    end
                    if (out_data.edge_overflow !== ex.edge_overflow)
                    begin
                        $error("edge_overflow expected %0b actual %0b",
                               ex.edge_overflow, out_data.edge_overflow);
                        fail_count++;
                    end
                    if (out_data.bad_vertex !== ex.bad_vertex)
                    begin
                        $error("bad_vertex expected %0b actual %0b",
                               ex.bad_vertex, out_data.bad_vertex);
                        fail_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("kruskal_mst_weight_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic add_edge(input int a, input int b, input int w, input bit last);
        edge_in_t e;
        e.vertex_a = a[5:0];
        e.vertex_b = b[5:0];
        e.weight = w[15:0];
        e.last_edge = last;
        edge_q.insert(edge_q.size(), e);
        if (last)
            graph_count++;
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (edge_q.size() != 0 || in_valid || forest_q.size() != 0);
    endtask

    task automatic set_vertex_count(input int v);
        wait_quiet();
        repeat (200) @(negedge clk);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v[VERTEX_COUNT_BITS-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        vc_model = v[VERTEX_COUNT_BITS-1:0];
    endtask

    function automatic int pick_weight();
        case ($urandom_range(5))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(7);
            default: return $urandom_range(65535);
        endcase
    endfunction

    // Mostly in-range edges; a few are drawn from 0 to 63 and may reach past the vertex limit.
    task automatic add_graph(input int n);
        int lim;
        int a;
        int b;
        lim = (vc_model > MAX_VERTICES) ? MAX_VERTICES : vc_model;
        for (int i = 0; i < n; i++)
        begin
            if (lim > 0 && $urandom_range(19) != 0)
            begin
                a = $urandom_range(lim - 1);
                b = $urandom_range(lim - 1);
            end
            else
            begin
                a = $urandom_range(63);
                b = $urandom_range(63);
            end
            add_edge(a, b, pick_weight(), i == n - 1);
        end
    endtask

    task automatic random_phase(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(9) == 0)
            begin
                case ($urandom_range(4))
                    0: set_vertex_count(1);
                    1: set_vertex_count(64);
                    2: set_vertex_count(127);
                    3: set_vertex_count(0);
                    default: set_vertex_count($urandom_range(2, 63));
                endcase
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            add_graph(n);
            sent += n;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        snd_idle_pct = 16;
        rcv_idle_pct = 77;
        drain_hold = 1'b0;
        fail_count = 0;
        graph_count = 0;
        result_count = 0;
        idle_cycles = 0;
        vc_model = VERTEX_COUNT_RESET;
        stored = 0;
        ovf_flag = 1'b0;
        bad_flag = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, self loop, equal weights, cycle rejection.
        add_edge(0, 63, 65535, 1);
        add_edge(5, 5, 100, 1);
        add_edge(1, 2, 7, 0);
        add_edge(2, 3, 7, 0);
        add_edge(1, 3, 7, 0);
        add_edge(3, 3, 0, 0);
        add_edge(63, 62, 0, 1);
        add_edge(10, 20, 500, 0);
        add_edge(20, 30, 100, 0);
        add_edge(10, 30, 200, 1);

        // Bad vertex, including a dropped last edge.
        set_vertex_count(5);
        add_edge(0, 4, 9, 0);
        add_edge(5, 1, 3, 0);
        add_edge(1, 2, 4, 1);
        add_edge(1, 3, 6, 0);
        add_edge(4, 63, 1, 1);
        set_vertex_count(0);
        add_edge(0, 0, 1, 1);
        set_vertex_count(127);
        add_edge(63, 0, 42, 0);
        add_edge(62, 63, 43, 1);
        set_vertex_count(1);
        add_edge(0, 0, 11, 0);
        add_edge(0, 1, 12, 1);

        set_vertex_count(64);
        random_phase(140);

        // Sender holds a queued graph back until every outstanding result is in.
        do
            @(negedge clk);
        while (edge_q.size() != 0 || in_valid);
        drain_hold = 1'b1;
        add_graph(8);
        do
            @(negedge clk);
        while (forest_q.size() != 0);
        drain_hold = 1'b0;

        wait_quiet();
        snd_idle_pct = 77;
        rcv_idle_pct = 16;
        random_phase(150);

        // One graph past the edge limit.
        set_vertex_count(64);
        for (int i = 0; i < MAX_EDGES + 3; i++)
            add_edge($urandom_range(63), $urandom_range(63), pick_weight(),
                     i == MAX_EDGES + 2);

        wait_quiet();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        random_phase(150);

        wait_quiet();
        repeat (300) @(posedge clk);
        $display("Sent %0d graphs, checked %0d results across vertex counts 0 to 127,",
                 graph_count, result_count);
        $display("with bad vertices, edge overflow and three idle patterns.");
        if (fail_count == 0)
            $display("kruskal_mst_weight_unit: match");
        else
            $display("kruskal_mst_weight_unit: mismatch");
        $finish;
    end

endmodule
